// ===== rtl/core/bls_pkg.sv =====
// bls_pkg: shared types and constants for the line stepper
// holds the transaction structs, action codes and derived widths; no dependencies
`timescale 1ns / 1ps

package bls_pkg;

  // coordinate width and widths derived from it
  localparam int COORD_BITS = 16;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int TWICE_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 4;

  // action codes of an input transaction
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  // input transaction
  typedef struct packed {
    action_e                 action;
    logic [COORD_BITS-1:0]   start_x;
    logic [COORD_BITS-1:0]   start_y;
    logic [COORD_BITS-1:0]   end_x;
    logic [COORD_BITS-1:0]   end_y;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } out_t;

endpackage

// ===== rtl/core/bresenham_line_stepper.sv =====
// bresenham_line_stepper: integer line rasterizer, one pixel per step transaction on a running line
// depends on bls_pkg for transaction types, action codes and widths
`timescale 1ns / 1ps

// Usage
// - input channel (in_valid_i / in_stall_o / in_data_i): a transaction with
//   action ACT_LOAD sets up a line from start to end and gives no result;
//   a load while a line is running replaces it. A transaction with action
//   ACT_STEP emits the next pixel of the line; the coordinate fields of a
//   step are ignored, and a step with no line running gives no result.
// - output channel (out_valid_o / out_stall_i / out_data_o): one pixel per
//   accepted step, last_pixel set on the second endpoint, after which the
//   line is finished. Pixels always run from the first endpoint.
// - throughput: one transaction per cycle while in_stall_o is low; the
//   result register is written at the accepting edge. The step path is one
//   error add with its sign test, the load path one delta subtract, magnitude
//   compare and error setup, both closing directly into the state registers.
// - while the receiver stalls a waiting result, in_stall_o is high; once the
//   result is taken a new transaction is accepted in the same cycle.
// - reset clears the line and the output valid; no line is running.
module bresenham_line_stepper
  import bls_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // line state
  logic                         line_active_q, line_active_d;
  logic                         steep_q, steep_d;
  logic                         backward_q, backward_d;
  logic signed [COORD_BITS-1:0] major_pos_q, major_pos_d;
  logic signed [COORD_BITS-1:0] minor_pos_q, minor_pos_d;
  logic signed [COORD_BITS-1:0] major_stop_q, major_stop_d;
  logic signed [1:0]            minor_dir_q, minor_dir_d;
  logic signed [ERR_BITS-1:0]   err_q, err_d;
  logic        [TWICE_BITS-1:0] twice_min_q, twice_min_d;
  logic        [TWICE_BITS-1:0] twice_maj_q, twice_maj_d;

  // output register
  logic out_valid_q, out_valid_d;
  out_t out_data_q, out_data_d;

  logic in_accept;
  logic is_load;
  logic is_step;

  // load path signals
  logic signed [DELTA_BITS-1:0] dx, dy, dmaj, dmin;
  logic        [DELTA_BITS-1:0] dx_neg, dy_neg;
  logic        [COORD_BITS-1:0] mag_dx, mag_dy, mag_maj, mag_min;
  logic                         load_steep;

  // step path signals
  logic                         at_stop;
  logic                         move_minor;
  logic signed [ERR_BITS-1:0]   err_step;

  // handshake
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign is_load    = in_accept & (in_data_i.action == ACT_LOAD);
  assign is_step    = in_accept & (in_data_i.action == ACT_STEP);

  // deltas and magnitudes of a load
  always_comb begin
    dx = $signed({in_data_i.end_x[COORD_BITS-1], in_data_i.end_x})
       - $signed({in_data_i.start_x[COORD_BITS-1], in_data_i.start_x});
    dy = $signed({in_data_i.end_y[COORD_BITS-1], in_data_i.end_y})
       - $signed({in_data_i.start_y[COORD_BITS-1], in_data_i.start_y});
    dx_neg = -dx;
    dy_neg = -dy;
    mag_dx = dx[DELTA_BITS-1] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    mag_dy = dy[DELTA_BITS-1] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    load_steep = mag_dy > mag_dx;
    if (load_steep) begin
      dmaj    = dy;
      dmin    = dx;
      mag_maj = mag_dy;
      mag_min = mag_dx;
    end else begin
      dmaj    = dx;
      dmin    = dy;
      mag_maj = mag_dx;
      mag_min = mag_dy;
    end
  end

  // error update of a step
  always_comb begin
    at_stop = major_pos_q == major_stop_q;
    if (backward_q) begin
      move_minor = ~err_q[ERR_BITS-1];
    end else begin
      move_minor = ~err_q[ERR_BITS-1] & (err_q != '0);
    end
    err_step = err_q
             + $signed({{(ERR_BITS-TWICE_BITS){1'b0}}, twice_min_q})
             - (move_minor ? $signed({{(ERR_BITS-TWICE_BITS){1'b0}}, twice_maj_q})
                           : $signed({ERR_BITS{1'b0}}));
  end

  // next state of the line and the output register
  always_comb begin
    line_active_d = line_active_q;
    steep_d       = steep_q;
    backward_d    = backward_q;
    major_pos_d   = major_pos_q;
    minor_pos_d   = minor_pos_q;
    major_stop_d  = major_stop_q;
    minor_dir_d   = minor_dir_q;
    err_d         = err_q;
    twice_min_d   = twice_min_q;
    twice_maj_d   = twice_maj_q;
    out_valid_d   = out_valid_q & out_stall_i;
    out_data_d    = out_data_q;

    if (is_load) begin
      line_active_d = 1'b1;
      steep_d       = load_steep;
      backward_d    = dmaj[DELTA_BITS-1];
      if (load_steep) begin
        major_pos_d  = in_data_i.start_y;
        major_stop_d = in_data_i.end_y;
        minor_pos_d  = in_data_i.start_x;
      end else begin
        major_pos_d  = in_data_i.start_x;
        major_stop_d = in_data_i.end_x;
        minor_pos_d  = in_data_i.start_y;
      end
      priority if (dmin[DELTA_BITS-1]) begin
        minor_dir_d = -2'sd1;
      end else if (dmin != '0) begin
        minor_dir_d = 2'sd1;
      end else begin
        minor_dir_d = 2'sd0;
      end
      twice_min_d = {mag_min, 1'b0};
      twice_maj_d = {mag_maj, 1'b0};
      err_d = $signed({{(ERR_BITS-TWICE_BITS){1'b0}}, mag_min, 1'b0})
            - $signed({{(ERR_BITS-COORD_BITS){1'b0}}, mag_maj});
    end else if (is_step && line_active_q) begin
      out_valid_d           = 1'b1;
      out_data_d.pixel_x    = steep_q ? minor_pos_q : major_pos_q;
      out_data_d.pixel_y    = steep_q ? major_pos_q : minor_pos_q;
      out_data_d.last_pixel = at_stop;
      if (at_stop) begin
        line_active_d = 1'b0;
      end else begin
        if (move_minor) begin
          minor_pos_d = minor_pos_q
                      + {{(COORD_BITS-2){minor_dir_q[1]}}, minor_dir_q};
        end
        err_d       = err_step;
        major_pos_d = backward_q ? major_pos_q - COORD_BITS'(1)
                                 : major_pos_q + COORD_BITS'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      line_active_q <= line_active_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    steep_q      <= steep_d;
    backward_q   <= backward_d;
    major_pos_q  <= major_pos_d;
    minor_pos_q  <= minor_pos_d;
    major_stop_q <= major_stop_d;
    minor_dir_q  <= minor_dir_d;
    err_q        <= err_d;
    twice_min_q  <= twice_min_d;
    twice_maj_q  <= twice_maj_d;
    out_data_q   <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a step with no line running leaves the output empty
  a_idle_step_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_step && !line_active_q) |=> !out_valid_o)
    else $error("result produced by a step with no line");

  // a step on a running line always produces a pixel
  a_active_step_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_step && line_active_q) |=> out_valid_o)
    else $error("step on a running line produced no pixel");

  // a load starts a line and gives no result
  a_load_starts_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_load |=> (line_active_q && !out_valid_o))
    else $error("load did not start a line cleanly");

  // the last pixel ends the line
  a_last_ends_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_step && line_active_q && at_stop) |=> !line_active_q)
    else $error("line still running after its last pixel");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for bresenham_line_stepper
// depends on bls_pkg and the block; a line tracker predicts every pixel and checks results in order
`timescale 1ns / 1ps

module tb;
  import bls_pkg::*;

  localparam int COORD_MIN   = -(2 ** (COORD_BITS - 1));
  localparam int COORD_MAX   = 2 ** (COORD_BITS - 1) - 1;
  localparam int QUIET_LIMIT = 2000;

  // predicts the pixels of the current line and holds those not yet seen
  class line_tracker;
    bit   line_on;
    bit   steep;
    bit   backward;
    int   major_at;
    int   minor_at;
    int   major_end;
    int   minor_step;
    int   err;
    int   twice_minor;
    int   twice_major;
    out_t pixels_due[$];
    int   mismatches     = 0;
    int   pixels_checked = 0;
    int   lines_loaded   = 0;
    int   steep_lines    = 0;
    int   backward_lines = 0;

    static function int magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    function void report(string what);
      if (mismatches < 40) $display("tb: mismatch: %s", what);
      mismatches++;
    endfunction

    // note an accepted input transaction
    function void take_transaction(in_t t);
      int   sx, sy, ex, ey, d_major, d_minor;
      out_t pix;
      if (t.action == ACT_LOAD) begin
        sx = int'($signed(t.start_x));
        sy = int'($signed(t.start_y));
        ex = int'($signed(t.end_x));
        ey = int'($signed(t.end_y));
        steep = magnitude(ey - sy) > magnitude(ex - sx);
        if (steep) begin
          major_at = sy; major_end = ey; minor_at = sx;
          d_major = ey - sy; d_minor = ex - sx;
        end else begin
          major_at = sx; major_end = ex; minor_at = sy;
          d_major = ex - sx; d_minor = ey - sy;
        end
        backward    = d_major < 0;
        minor_step  = (d_minor > 0) ? 1 : (d_minor < 0) ? -1 : 0;
        twice_minor = 2 * magnitude(d_minor);
        twice_major = 2 * magnitude(d_major);
        err         = twice_minor - magnitude(d_major);
        line_on     = 1'b1;
        lines_loaded++;
        if (steep) steep_lines++;
        if (backward) backward_lines++;
      end else if (line_on) begin
        pix.pixel_x    = COORD_BITS'(steep ? minor_at : major_at);
        pix.pixel_y    = COORD_BITS'(steep ? major_at : minor_at);
        pix.last_pixel = (major_at == major_end);
        pixels_due     = {pixels_due, pix};
        if (pix.last_pixel) begin
          line_on = 1'b0;
        end else begin
          // backward walks use the mirrored tie rule
          if (backward ? (err >= 0) : (err > 0)) begin
            minor_at += minor_step;
            err      -= twice_major;
          end
          err      += twice_minor;
          major_at += backward ? -1 : 1;
        end
      end
    endfunction

    // compare a result transaction with the oldest predicted pixel
    function void check_pixel(out_t got);
      out_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel (%0d,%0d) with none expected",
                         $signed(got.pixel_x), $signed(got.pixel_y)));
        return;
      end
      want = pixels_due.pop_front();
      if (got.pixel_x !== want.pixel_x)
        report($sformatf("pixel %0d x got %0d want %0d", pixels_checked,
                         $signed(got.pixel_x), $signed(want.pixel_x)));
      if (got.pixel_y !== want.pixel_y)
        report($sformatf("pixel %0d y got %0d want %0d", pixels_checked,
                         $signed(got.pixel_y), $signed(want.pixel_y)));
      if (got.last_pixel !== want.last_pixel)
        report($sformatf("pixel %0d last got %b want %b", pixels_checked,
                         got.last_pixel, want.last_pixel));
      pixels_checked++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  line_tracker tracker = new();
  bit          sender_idles;
  bit          recv_idles;
  int          hold_len;
  int          sent;

  bresenham_line_stepper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // offer one transaction, with an optional idle burst ahead of it
  task automatic send_item(input in_t item);
    int gap;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_transaction(item);
    sent++;
  endtask

  task automatic send_load(input int sx, input int sy, input int ex, input int ey);
    in_t it;
    it.action  = ACT_LOAD;
    it.start_x = COORD_BITS'(sx);
    it.start_y = COORD_BITS'(sy);
    it.end_x   = COORD_BITS'(ex);
    it.end_y   = COORD_BITS'(ey);
    send_item(it);
  endtask

  // step transactions carry random coordinates, which the block ignores
  task automatic send_steps(input int n);
    in_t it;
    repeat (n) begin
      it        = in_t'({$urandom, $urandom});
      it.action = ACT_STEP;
      send_item(it);
    end
  endtask

  // drop valid and wait for every predicted pixel
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_coord();
    logic signed [COORD_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      default: begin
        v = COORD_BITS'($urandom);
        return int'(v);
      end
    endcase
  endfunction

  // mostly short lines stepped to the end; some cut short, overstepped or huge
  task automatic run_random(input int target);
    int made, kind, reach, sx, sy, ex, ey, span, steps;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 11);
      sx   = pick_coord();
      sy   = pick_coord();
      if (kind == 0) begin
        ex = pick_coord();
        ey = pick_coord();
      end else begin
        reach = (kind == 1) ? 60 : (kind == 4) ? 2 : 8;
        ex = sx + int'($urandom_range(0, 2 * reach)) - reach;
        ey = sy + int'($urandom_range(0, 2 * reach)) - reach;
        // mirror an end that would leave the coordinate range
        if (ex > COORD_MAX || ex < COORD_MIN) ex = 2 * sx - ex;
        if (ey > COORD_MAX || ey < COORD_MIN) ey = 2 * sy - ey;
      end
      span = line_tracker::magnitude(ex - sx);
      if (line_tracker::magnitude(ey - sy) > span) span = line_tracker::magnitude(ey - sy);
      span++;
      if (kind == 0) steps = $urandom_range(0, 6);
      else if (kind == 2) steps = $urandom_range(0, span - 1);
      else if (kind == 3) steps = span + $urandom_range(1, 2);
      else steps = span;
      send_load(sx, sy, ex, ey);
      send_steps(steps);
      made += 1 + ((steps < span) ? steps : span);
    end
  endtask

  // receiver stall: random bursts, or one long hold on request
  initial begin : receiver
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        stall_left = hold_len;
        hold_len   = 0;
      end else if (stall_left == 0 && recv_idles && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_pixel(out_data_o);
  end

  // watchdog: ends the run after too many cycles without a transaction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    sender_idles = 1'b1;
    recv_idles   = 1'b1;
    hold_len     = 0;
    sent         = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: step with no line, single pixel, extremes, each walk direction
    send_steps(1);
    send_load(5, -7, 5, -7);
    send_steps(1);
    send_load(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_steps(2);
    send_load(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_steps(1);
    send_load(3, 1, 0, 0);
    send_steps(4);
    send_load(0, 0, 1, 3);
    send_steps(4);
    send_load(2, 0, 0, -3);
    send_steps(4);
    send_load(0, 0, -2, 2);
    send_steps(4);

    run_random(200);

    // sender pause until drained, then a long receiver hold against back-to-back steps
    wait_drained();
    sender_idles = 1'b0;
    hold_len     = 120;
    send_load(-100, 40, -70, 29);
    send_steps(20);
    sender_idles = 1'b1;

    run_random(180);

    // closing stretch with no idling on either side
    sender_idles = 1'b0;
    recv_idles   = 1'b0;
    run_random(100);

    wait_drained();
    repeat (5) @(posedge clk_i);

    $display("tb: %0d transactions sent, %0d lines loaded, %0d pixels checked",
             sent, tracker.lines_loaded, tracker.pixels_checked);
    $display("tb: %0d steep lines, %0d walked backward, %0d mismatches",
             tracker.steep_lines, tracker.backward_lines, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
